FILE: hdl/mbce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_pkg
// Shared types and constants of the message block cipher engine: work
// descriptors passed from the front end to the cipher back end, back-end
// status and state codes, register indexes and TEA constants.
// ----------------------------------------------------------------------------
package mbce_pkg;

  localparam logic [31:0] ROUND_DELTA = 32'h9E37_79B9;
  localparam int          QUEUE_DEPTH = 2;
  localparam int          CFG_INDEX_W = 1;

  // Item kinds on the input channel
  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_CHUNK  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b1;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_ENC,
    OP_DEC,
    OP_TAIL
  } mbce_op_t;

  typedef struct packed {
    mbce_op_t    op;
    logic [63:0] data;
    logic [2:0]  tail_n;
    logic        done;
  } mbce_desc_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } mbce_bk_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_HOLD
  } mbce_bk_state_t;

endpackage

FILE: hdl/mbce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_front
// Accepts header and payload items, tracks the current message and turns
// each item into a work descriptor for the cipher back end.
// ----------------------------------------------------------------------------
module mbce_front
  import mbce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic        direction,
  input  logic [63:0] data_in,
  input  logic        q_full,
  output logic        q_push,
  output mbce_desc_t  q_desc
);

  logic        decrypting;
  logic [8:0]  blocks_left;
  logic [2:0]  tail_left;
  logic        message_active;

  logic        decrypting_next;
  logic [8:0]  blocks_left_next;
  logic [2:0]  tail_left_next;
  logic        message_active_next;

  logic [11:0] hdr_len;
  logic [11:0] payload;
  logic        allowed;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  assign hdr_len = data_in[15:4];
  assign allowed = direction ? data_in[0] : ~data_in[0];
  // lengths under two mean no payload
  assign payload = (hdr_len >= 12'd2) ? (hdr_len - 12'd2) : 12'd0;

  always_comb begin
    decrypting_next     = decrypting;
    blocks_left_next    = blocks_left;
    tail_left_next      = tail_left;
    message_active_next = message_active;
    q_desc.op     = OP_PASS;
    q_desc.data   = data_in;
    q_desc.tail_n = tail_left;
    q_desc.done   = 1'b1;
    if (action == ACT_HEADER) begin
      // a new header always drops whatever message was open
      decrypting_next     = direction;
      blocks_left_next    = 9'd0;
      tail_left_next      = 3'd0;
      message_active_next = 1'b0;
      if (allowed) begin
        blocks_left_next    = payload[11:3];
        tail_left_next      = payload[2:0];
        message_active_next = |payload;
        q_desc.data         = {data_in[63:1], ~direction};
        q_desc.done         = ~|payload;
      end
    end else if (message_active) begin
      if (|blocks_left) begin
        q_desc.op        = decrypting ? OP_DEC : OP_ENC;
        blocks_left_next = blocks_left - 9'd1;
      end else begin
        q_desc.op      = OP_TAIL;
        tail_left_next = 3'd0;
      end
      message_active_next = (|blocks_left_next) | (|tail_left_next);
      q_desc.done         = ~message_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypting     <= 1'b0;
      blocks_left    <= 9'd0;
      tail_left      <= 3'd0;
      message_active <= 1'b0;
    end else if (q_push) begin
      decrypting     <= decrypting_next;
      blocks_left    <= blocks_left_next;
      tail_left      <= tail_left_next;
      message_active <= message_active_next;
    end
  end

endmodule

FILE: hdl/mbce_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_queue
// Short descriptor queue between the front end and the cipher back end.
// ----------------------------------------------------------------------------
module mbce_queue
  import mbce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  mbce_desc_t push_desc,
  input  logic       pop,
  output logic       full,
  output logic       head_valid,
  output mbce_desc_t head_desc
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mbce_desc_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_desc  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/mbce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_back
// Cipher back end: runs one TEA round per cycle for full blocks, applies
// the tail mask or passes data through, and holds the result register.
// ----------------------------------------------------------------------------
module mbce_back
  import mbce_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   key_low,
  input  logic [31:0]   key_high,
  input  logic          q_valid,
  input  mbce_desc_t    q_desc,
  output mbce_bk_stat_t stat,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [63:0]   data_out,
  output logic          applied,
  output logic          message_done
);

  localparam int          CNT_W    = $clog2(ROUNDS + 1);
  localparam logic [31:0] SUM_INIT = 32'(64'(ROUND_DELTA) * 64'(ROUNDS));

  mbce_bk_state_t state;
  mbce_bk_state_t state_next;

  logic [31:0]      a;
  logic [31:0]      b;
  logic [31:0]      s;
  logic [CNT_W-1:0] cnt;
  logic             dec;
  logic             res_applied;
  logic             res_done;

  logic        out_free;
  logic        load;
  logic        finish;
  logic        load_tea;
  logic        last;
  logic [63:0] key;
  logic [63:0] tail_data;
  logic [31:0] enc_a;
  logic [31:0] enc_b;
  logic [31:0] dec_a;
  logic [31:0] dec_b;

  function automatic logic [31:0] tea_mix(input logic [31:0] x, input logic [31:0] sum,
                                          input logic [31:0] k0, input logic [31:0] k1);
    tea_mix = ((x << 4) + k0) ^ (x + sum) ^ ((x >> 5) + k1);
  endfunction

  assign key      = {key_high, key_low};
  assign out_free = ~out_valid | ~out_stall;
  assign finish   = (state == BK_HOLD) & out_free;
  assign load     = q_valid & ((state == BK_IDLE) | finish);
  assign load_tea = (q_desc.op == OP_ENC) | (q_desc.op == OP_DEC);
  assign last     = (cnt == CNT_W'(1));

  assign stat.busy = (state != BK_IDLE);
  assign stat.pop  = load;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < {1'b0, q_desc.tail_n}) begin
        tail_data[i*8 +: 8] = ~(q_desc.data[i*8 +: 8] ^ key[i*8 +: 8]);
      end else begin
        tail_data[i*8 +: 8] = q_desc.data[i*8 +: 8];
      end
    end
  end

  assign enc_a = a + tea_mix(b, s, key_low, key_high);
  assign enc_b = b + tea_mix(enc_a, s, key_low, key_high);
  assign dec_b = b - tea_mix(a, s, key_low, key_high);
  assign dec_a = a - tea_mix(dec_b, s, key_low, key_high);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = load_tea ? BK_ROUND : BK_HOLD;
        end
      end
      BK_ROUND: begin
        if (last) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          if (q_valid) begin
            state_next = load_tea ? BK_ROUND : BK_HOLD;
          end else begin
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_applied <= (q_desc.op != OP_PASS);
      res_done    <= q_desc.done;
      dec         <= (q_desc.op == OP_DEC);
      if (load_tea) begin
        a   <= q_desc.data[31:0];
        b   <= q_desc.data[63:32];
        s   <= (q_desc.op == OP_DEC) ? SUM_INIT : ROUND_DELTA;
        cnt <= CNT_W'(ROUNDS);
      end else if (q_desc.op == OP_TAIL) begin
        a <= tail_data[31:0];
        b <= tail_data[63:32];
      end else begin
        a <= q_desc.data[31:0];
        b <= q_desc.data[63:32];
      end
    end else if (state == BK_ROUND) begin
      a   <= dec ? dec_a : enc_a;
      b   <= dec ? dec_b : enc_b;
      s   <= dec ? (s - ROUND_DELTA) : (s + ROUND_DELTA);
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      data_out     <= {b, a};
      applied      <= res_applied;
      message_done <= res_done;
    end
  end

endmodule

FILE: hdl/message_block_cipher_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_block_cipher_engine
// TEA-style, 64-bit block and key, on one message: header, then payload chunks.
//
// Channel  Handshake              Payload
// in       in_valid / in_stall    action, direction, data_in
// out      out_valid / out_stall  data_out, applied, message_done
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// In the back end a full block runs one TEA round per cycle in BK_ROUND, then
// moves from BK_HOLD into the output register once it is free. Headers and
// pass-through and tail chunks move at one item per cycle if out_stall is low.
// A two-entry queue separates the front end from the back end, so input is
// taken while a block is under way or a result waits on out_stall.
// Reset is synchronous and clears keys, message state, queue and out_valid.
// ----------------------------------------------------------------------------
module message_block_cipher_engine
  import mbce_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   action,
  input  logic                   direction,
  input  logic [63:0]            data_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [63:0]            data_out,
  output logic                   applied,
  output logic                   message_done,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  logic [31:0]   key_word_low;
  logic [31:0]   key_word_high;
  logic          q_push;
  logic          q_full;
  logic          q_valid;
  mbce_desc_t    push_desc;
  mbce_desc_t    head_desc;
  mbce_bk_stat_t bk_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_low  <= 32'd0;
      key_word_high <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_LOW:  key_word_low  <= cfg_data;
        REG_KEY_HIGH: key_word_high <= cfg_data;
        default: ;
      endcase
    end
  end

  mbce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .direction (direction),
    .data_in   (data_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  mbce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (push_desc),
    .pop        (bk_stat.pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  mbce_back #(
    .ROUNDS (ROUNDS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .key_low      (key_word_low),
    .key_high     (key_word_high),
    .q_valid      (q_valid),
    .q_desc       (head_desc),
    .stat         (bk_stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_out     (data_out),
    .applied      (applied),
    .message_done (message_done)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    bk_stat.pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(bk_stat.busy))
    else $error("result appeared without work in the back end");

  a_result_dropped: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result left the output register while stalled");

endmodule
